// File: hdl/mahpf_pkg.sv
// ----------------------------------------------------------------------------
// mahpf_pkg
// Shared constants and types for the centred moving-average high-pass filter.
// ----------------------------------------------------------------------------
package mahpf_pkg;

  localparam int MAX_SPAN     = 31;
  localparam int SAMPLE_WIDTH = 24;
  localparam int SPAN_W       = 5;
  localparam int SPAN_RESET   = 15;

  localparam int LINE_DEPTH   = 2 * MAX_SPAN + 1;
  localparam int IDX_W        = $clog2(LINE_DEPTH + 1);
  localparam int SUM_W        = SAMPLE_WIDTH + IDX_W;
  localparam int OUT_WIDTH    = SAMPLE_WIDTH + 1;
  localparam int IN_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_WIDTH + 7) / 8) * 8;
  localparam int DIV_CNT_W    = $clog2(SUM_W);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic [IDX_W-1:0]               idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_WIN,
    S_SUM,
    S_DRAIN,
    S_DIVGO,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// File: hdl/mahpf_div.sv
// ----------------------------------------------------------------------------
// mahpf_div
// Radix-2 restoring divider, signed window sum by unsigned window count,
// quotient truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module mahpf_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mahpf_pkg::sum_t      dividend,
  input  mahpf_pkg::idx_t      divisor,
  output logic                 done,
  output mahpf_pkg::sum_t      quotient
);
  import mahpf_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [SUM_W-1:0]     mag;
  idx_t                 rem;
  idx_t                 dvs;
  logic [IDX_W:0]       trial;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem, mag[SUM_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      mag <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[IDX_W]) begin
        rem <= trial[IDX_W-1:0];
        mag <= {mag[SUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[IDX_W-2:0], mag[SUM_W-1]};
        mag <= {mag[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? sum_t'(-mag) : sum_t'(mag);

endmodule

// File: hdl/moving_average_high_pass_filter_unit.sv
// ----------------------------------------------------------------------------
// moving_average_high_pass_filter_unit
// Centred moving-average high-pass filter: sample minus mean of its window.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry one sample; tlast marks the end of a series.
// Output beats on m_axis carry the filtered sample; tlast marks the final
// result of a series. cfg_we/cfg_wdata set the half window span (reset 15),
// to be written only while the block is idle.
// Samples are kept in a circular buffer of 2*MAX_SPAN+1 entries. Each result
// walks its window through the single buffer read port, one sample a cycle,
// then runs the 30-step serial divider; every input beat is first accepted
// and set up. A normal beat yields at most one result; a tlast beat flushes
// up to span+1 results, each with its own window walk and division.
// s_axis_tready is high only while no beat is in work. A finished result
// sits in the output register; the next result is computed meanwhile and
// waits only if that register has not yet been taken.
// Reset empties the series and restores the span; buffer contents are left
// as they are and are never read before being rewritten.
// ----------------------------------------------------------------------------
module moving_average_high_pass_filter_unit (
  input  logic                               clk,
  input  logic                               rst,
  // tdata: sample_in
  input  logic [mahpf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                               s_axis_tlast,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: filtered_out
  output logic [mahpf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we,
  input  logic [mahpf_pkg::SPAN_W-1:0]       cfg_wdata
);
  import mahpf_pkg::*;

  sample_t mem [LINE_DEPTH];

  state_t  state, state_next;
  logic [SPAN_W-1:0] window_span;
  idx_t    span;
  idx_t    head, head_next;
  idx_t    seen, seen_next;
  logic    end_r, end_next;
  idx_t    age, age_next;
  idx_t    k, k_next;
  idx_t    hi, hi_next;
  idx_t    count, count_next;
  sum_t    acc, acc_next;
  sample_t samp, samp_next;
  logic    rd_v, rd_v_next;
  idx_t    rd_age, rd_age_next;
  sample_t rdata;
  logic    rd_issue;
  idx_t    rd_addr;
  logic    mem_we;
  logic    div_start, div_done;
  sum_t    quot;
  logic    out_valid, out_valid_next;
  logic [OUT_WIDTH-1:0] out_data, out_data_next;
  logic    out_last, out_last_next;
  idx_t    right, left, older, seen_m1;
  logic [IDX_W:0] diff;

  assign span = (int'(window_span) > MAX_SPAN) ? IDX_W'(MAX_SPAN) : IDX_W'(window_span);

  // window bounds for the position at the current age
  assign seen_m1 = seen - 1'b1;
  assign older   = seen_m1 - age;
  assign right   = (age < span) ? age : span;
  assign left    = (older < span) ? older : span;

  // age to buffer address: newest sample sits at head
  assign diff    = {1'b0, head} - {1'b0, k};
  assign rd_addr = diff[IDX_W] ? IDX_W'(diff + (IDX_W + 1)'(LINE_DEPTH)) : diff[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[head_next] <= sample_t'(s_axis_tdata[SAMPLE_WIDTH-1:0]);
    if (rd_issue) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_span <= SPAN_W'(SPAN_RESET);
    end else if (cfg_we) begin
      window_span <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      seen      <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      seen      <= seen_next;
      rd_v      <= rd_v_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    end_r    <= end_next;
    age      <= age_next;
    k        <= k_next;
    hi       <= hi_next;
    count    <= count_next;
    acc      <= acc_next;
    samp     <= samp_next;
    rd_age   <= rd_age_next;
    out_data <= out_data_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    seen_next      = seen;
    end_next       = end_r;
    age_next       = age;
    k_next         = k;
    hi_next        = hi;
    count_next     = count;
    acc_next       = acc;
    samp_next      = samp;
    rd_v_next      = 1'b0;
    rd_age_next    = rd_age;
    out_data_next  = out_data;
    out_last_next  = out_last;
    out_valid_next = out_valid && !m_axis_tready;
    mem_we         = 1'b0;
    rd_issue       = 1'b0;
    div_start      = 1'b0;
    s_axis_tready  = (state == S_IDLE);

    if (rd_v) begin
      acc_next = acc + sum_t'(rdata);
      if (rd_age == age) samp_next = rdata;
    end

    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mem_we     = 1'b1;
          head_next  = (head == IDX_W'(LINE_DEPTH - 1)) ? '0 : head + 1'b1;
          seen_next  = (seen < IDX_W'(LINE_DEPTH)) ? seen + 1'b1 : seen;
          end_next   = s_axis_tlast;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (end_r) begin
          age_next   = (seen_m1 < span) ? seen_m1 : span;
          state_next = S_WIN;
        end else if (seen > span) begin
          age_next   = span;
          state_next = S_WIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WIN: begin
        k_next     = age - right;
        hi_next    = age + left;
        count_next = left + right + 1'b1;
        acc_next   = '0;
        state_next = S_SUM;
      end
      S_SUM: begin
        rd_issue    = 1'b1;
        rd_v_next   = 1'b1;
        rd_age_next = k;
        if (k == hi) begin
          state_next = S_DRAIN;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = OUT_WIDTH'(samp) - OUT_WIDTH'(quot);
          out_last_next  = end_r && (age == '0);
          if (end_r && (age != '0)) begin
            age_next   = age - 1'b1;
            state_next = S_WIN;
          end else begin
            if (end_r) seen_next = '0;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  mahpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (count),
    .done     (div_done),
    .quotient (quot)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);
  assign m_axis_tlast  = out_last;

endmodule

// File: dv/moving_average_high_pass_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// moving_average_high_pass_filter_unit_tb
// Self-checking bench for the centred moving-average high-pass filter.
// Short hand-picked series come first: a lone sample, zero span, a series
// shorter than the span, a span change part-way through a series, and full
// scale swings. Random series follow under three stall patterns. Every
// accepted input beat updates a local copy of the delay line, and the
// filtered beats that it should produce are queued. Each output beat is
// checked against the head of that queue.
// ----------------------------------------------------------------------------
module moving_average_high_pass_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mahpf_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [SPAN_W-1:0]       SPAN_TOP   = SPAN_W'(MAX_SPAN);

  typedef struct packed {
    logic [OUT_WIDTH-1:0] value;
    logic                 last;
  } filtered_beat_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_we;
  logic [SPAN_W-1:0]      cfg_wdata;

  // local copy of the filter state
  logic signed [SAMPLE_WIDTH-1:0] sample_line [LINE_DEPTH];
  int                             series_len;
  int                             span_cur;
  filtered_beat_t                 expected_filtered[$];

  int send_idle_pct;
  int recv_idle_pct;
  int failures;
  int beats_sent;
  int series_done;
  int results_seen;
  int cycle_count;

  moving_average_high_pass_filter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[moving_average_high_pass_filter_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // sample at the given age minus the mean of its (possibly shrunken) window
  function automatic logic [OUT_WIDTH-1:0] centred_result(int age, int span);
    int     right, older, left, lo, hi, a;
    longint total, count, diff;
    right = (age < span) ? age : span;
    older = series_len - 1 - age;
    left  = (older < span) ? older : span;
    lo    = age - right;
    hi    = age + left;
    count = longint'(left + right + 1);
    total = 0;
    for (a = lo; a <= hi && a < LINE_DEPTH; a++) total += longint'(sample_line[a]);
    diff = longint'(sample_line[age]) - total / count;
    return diff[OUT_WIDTH-1:0];
  endfunction

  function automatic void predict_beat(logic [SAMPLE_WIDTH-1:0] smp, logic eos);
    int i, first;
    for (i = LINE_DEPTH - 1; i > 0; i--) sample_line[i] = sample_line[i-1];
    sample_line[0] = smp;
    if (series_len < LINE_DEPTH) series_len++;
    if (!eos) begin
      if (series_len > span_cur)
        expected_filtered.push_back('{value: centred_result(span_cur, span_cur), last: 1'b0});
    end else begin
      // flush: oldest outstanding position first, newest carries tlast
      first = (series_len - 1 < span_cur) ? series_len - 1 : span_cur;
      for (i = first; i >= 0; i--)
        expected_filtered.push_back('{value: centred_result(i, span_cur), last: (i == 0)});
      series_len = 0;
      series_done++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    filtered_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_filtered.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        failures++;
      end else begin
        want = expected_filtered.pop_front();
        if (m_axis_tdata !== {{(OUT_TDATA_W-OUT_WIDTH){1'b0}}, want.value}) begin
          $display("%0t: filtered mismatch, expected %h actual %h",
                   $time, want.value, m_axis_tdata);
          failures++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: tlast mismatch, expected %b actual %b",
                   $time, want.last, m_axis_tlast);
          failures++;
        end
      end
    end
  end

  task automatic send_sample(logic [SAMPLE_WIDTH-1:0] smp, logic eos);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tdata  <= smp;
    s_axis_tlast  <= eos;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_beat(smp, eos);
    beats_sent++;
  endtask

  // hold the sender off until every queued result is out and the block is quiet
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_span(logic [SPAN_W-1:0] span);
    wait_drain();
    cfg_wdata <= span;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    span_cur = int'(span);
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_WIDTH'($urandom_range(511) - 256);
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  task automatic test_single_sample();
    send_sample(SAMPLE_MAX, 1'b1);
  endtask

  task automatic test_zero_span();
    write_span('0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(24'h123456, 1'b1);
  endtask

  task automatic test_short_series();
    write_span(SPAN_TOP);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
  endtask

  task automatic test_span_change();
    int k;
    write_span(5'd2);
    for (k = 0; k < 4; k++) send_sample(rand_sample(), 1'b0);
    write_span(5'd1);
    for (k = 0; k < 4; k++) send_sample(rand_sample(), k == 3);
  endtask

  task automatic test_extremes();
    write_span(5'd3);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
  endtask

  task automatic test_random_series(int snd_pct, int rcv_pct, int n_items);
    int r, len, k, brk, sent;
    bit long_done;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent      = 0;
    long_done = 0;
    while (sent < n_items) begin
      r = $urandom_range(9);
      if (r == 0)      write_span('0);
      else if (r == 1) write_span(SPAN_TOP);
      else if (r == 2) write_span(SPAN_W'($urandom_range(MAX_SPAN)));
      else             write_span(SPAN_W'($urandom_range(1, 6)));
      // one long series per pattern so the sample count saturates
      if (!long_done) begin
        len       = $urandom_range(LINE_DEPTH + 1, LINE_DEPTH + 9);
        long_done = 1;
      end else if ($urandom_range(9) == 0) begin
        len = 1;
      end else begin
        len = $urandom_range(2, 14);
      end
      brk = (len > 1 && $urandom_range(9) == 0) ? $urandom_range(1, len - 1) : -1;
      for (k = 0; k < len; k++) begin
        if (k == brk) write_span(SPAN_W'($urandom_range(7)));
        send_sample(rand_sample(), k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tvalid <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    rst           <= 1'b1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    span_cur      = SPAN_RESET;
    series_len    = 0;
    failures      = 0;
    beats_sent    = 0;
    series_done   = 0;
    results_seen  = 0;
    cycle_count   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_single_sample();
    test_zero_span();
    test_short_series();
    test_span_change();
    test_extremes();

    test_random_series(37, 65, 80);
    test_random_series(65, 37, 80);
    test_random_series(0, 0, 81);

    s_axis_tvalid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d sample beats in %0d series, checked %0d filtered beats;",
             beats_sent, series_done, results_seen);
    $display("spans 0 to 31, short, single and saturating series, three stall patterns.");
    if (failures == 0) begin
      $display("[moving_average_high_pass_filter_unit] OK");
    end else begin
      $display("[moving_average_high_pass_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
